// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

	localparam int NSERVO = 6;
	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] LEN_SINGLE = 8'd8;
	localparam logic [7:0] LEN_GROUP = 8'h17;
	localparam logic [7:0] ID_FIRST = 8'h01;
	localparam logic [7:0] ID_LAST = 8'h06;
	localparam logic [4:0] POS_LEN = 5'd2;
	localparam logic [4:0] POS_MIN = 5'd3;
	localparam logic [4:0] POS_DUR_LO = 5'd5;
	localparam logic [4:0] POS_DUR_HI = 5'd6;
	localparam logic [4:0] POS_ID = 5'd7;
	localparam logic [4:0] POS_LO = 5'd8;
	localparam logic [4:0] POS_HI = 5'd9;
	localparam logic [4:0] SINGLE_BYTES = 5'd10;
	localparam logic [4:0] GROUP_BYTES = 5'd25;

	typedef enum logic [2:0] {
		ST_BAD_HDR = 3'd0,
		ST_SINGLE  = 3'd1,
		ST_GROUP   = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_SHORT   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ROLE_NONE = 2'd0,
		ROLE_ID   = 2'd1,
		ROLE_LO   = 2'd2,
		ROLE_HI   = 2'd3
	} slot_role_t;

	typedef struct packed {
		slot_role_t role;
		logic [2:0] idx;
	} slot_t;

	// parser state as it stands once the current byte is taken in
	typedef struct packed {
		logic [4:0]                   count;
		logic                         header_good;
		logic [7:0]                   length_code;
		logic [7:0]                   target_id;
		logic                         ids_in_order;
		logic [15:0]                  pend_dur;
		logic [NSERVO-1:0][15:0]      pend_goal;
	} frame_view_t;

	typedef struct packed {
		status_t                      status;
		logic                         applied;
		logic [15:0]                  move_duration;
		logic [NSERVO-1:0][15:0]      pulse;
	} result_t;

	// where a byte of a group frame lands: ID, low or high byte of servo idx
	function automatic slot_t group_slot(input logic [4:0] pos);
		slot_t s;
		s.role = ROLE_NONE;
		s.idx = '0;
		for (int k = 0; k < NSERVO; k++) begin
			if (pos == 5'(POS_ID + 3 * k)) begin
				s.role = ROLE_ID;
				s.idx = 3'(k);
			end
			if (pos == 5'(POS_ID + 3 * k + 1)) begin
				s.role = ROLE_LO;
				s.idx = 3'(k);
			end
			if (pos == 5'(POS_ID + 3 * k + 2)) begin
				s.role = ROLE_HI;
				s.idx = 3'(k);
			end
		end
		return s;
	endfunction

endpackage

// ===== hdl/sfd_parser.sv =====
module sfd_parser import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        last,
	input  logic [7:0]  rx_byte,
	output frame_view_t view
);

	logic [4:0]              pos_q;
	logic                    hdr_ok_q;
	logic [7:0]              len_q;
	logic [7:0]              id_q;
	logic [7:0]              lo_q;
	logic                    ids_ok_q;
	logic [15:0]             pend_dur_q;
	logic [NSERVO-1:0][15:0] pend_goal_q;

	logic [7:0] lo_next;
	slot_t      slot;

	assign slot = group_slot(pos_q);

	always_comb begin
		view.count = (pos_q == GROUP_BYTES) ? GROUP_BYTES : pos_q + 5'd1;
		view.header_good = hdr_ok_q;
		view.length_code = len_q;
		view.target_id = id_q;
		view.ids_in_order = ids_ok_q;
		view.pend_dur = pend_dur_q;
		view.pend_goal = pend_goal_q;
		lo_next = lo_q;
		if (pos_q < POS_LEN) begin
			if (rx_byte != HDR_BYTE) view.header_good = 1'b0;
		end else if (pos_q == POS_LEN) begin
			view.length_code = rx_byte;
		end else if (pos_q < GROUP_BYTES) begin
			if (len_q == LEN_SINGLE) begin
				if (pos_q == POS_ID) view.target_id = rx_byte;
				else if (pos_q == POS_LO) lo_next = rx_byte;
				else if (pos_q == POS_HI) view.pend_goal[0] = {rx_byte, lo_q};
			end else if (len_q == LEN_GROUP) begin
				if (pos_q == POS_DUR_LO) begin
					lo_next = rx_byte;
				end else if (pos_q == POS_DUR_HI) begin
					view.pend_dur = {rx_byte, lo_q};
				end else begin
					unique case (slot.role)
						ROLE_ID: if (rx_byte != 8'({5'd0, slot.idx} + 8'd1))
							view.ids_in_order = 1'b0;
						ROLE_LO: lo_next = rx_byte;
						ROLE_HI: view.pend_goal[slot.idx] = {rx_byte, lo_q};
						default: ;
					endcase
				end
			end
		end
	end

	// pending store keeps its contents across frames; only per-frame state is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_ok_q <= 1'b1;
			len_q <= '0;
			id_q <= '0;
			lo_q <= '0;
			ids_ok_q <= 1'b1;
		end else if (fire) begin
			if (last) begin
				pos_q <= '0;
				hdr_ok_q <= 1'b1;
				len_q <= '0;
				id_q <= '0;
				lo_q <= '0;
				ids_ok_q <= 1'b1;
			end else begin
				pos_q <= view.count;
				hdr_ok_q <= view.header_good;
				len_q <= view.length_code;
				id_q <= view.target_id;
				lo_q <= lo_next;
				ids_ok_q <= view.ids_in_order;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_dur_q <= view.pend_dur;
			pend_goal_q <= view.pend_goal;
		end
	end

endmodule

// ===== hdl/sfd_goal_store.sv =====
module sfd_goal_store import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        commit,
	input  frame_view_t view,
	output result_t     res
);

	logic [15:0]             dur_q;
	logic [NSERVO-1:0][15:0] goal_q;
	logic                    id_ok;

	assign id_ok = (view.target_id >= ID_FIRST) && (view.target_id <= ID_LAST);

	always_comb begin
		res.status = ST_UNKNOWN;
		res.applied = 1'b0;
		res.move_duration = dur_q;
		res.pulse = goal_q;
		priority if (!view.header_good) begin
			res.status = ST_BAD_HDR;
		end else if (view.count < POS_MIN) begin
			res.status = ST_SHORT;
		end else if (view.length_code == LEN_SINGLE) begin
			if (view.count < SINGLE_BYTES) begin
				res.status = ST_SHORT;
			end else begin
				res.status = ST_SINGLE;
				if (id_ok) begin
					res.applied = 1'b1;
					for (int i = 0; i < NSERVO; i++) begin
						if (view.target_id == 8'(i + 1)) res.pulse[i] = view.pend_goal[0];
					end
				end
			end
		end else if (view.length_code == LEN_GROUP) begin
			if (view.count < GROUP_BYTES) begin
				res.status = ST_SHORT;
			end else begin
				res.status = ST_GROUP;
				if (view.ids_in_order) begin
					res.applied = 1'b1;
					res.move_duration = view.pend_dur;
					res.pulse = view.pend_goal;
				end
			end
		end else begin
			res.status = ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= '0;
			goal_q <= '0;
		end else if (commit) begin
			dur_q <= res.move_duration;
			goal_q <= res.pulse;
		end
	end

endmodule

// ===== hdl/servo_command_frame_decoder.sv =====
// Channel   Handshake               Payload
// input     in_valid / in_ready     rx_byte[7:0], frame_end
// output    out_valid / out_ready   status[2:0], applied, move_duration[15:0],
//                                   pulse_ch0..pulse_ch5[15:0]
//
// One byte per cycle while out_ready does not stall the output. A byte is
// held in the input register, where the parser and goal store act on it; a
// frame_end beat gives its result beat from the output register. Reset
// clears per-frame state, goals and move time; pending values are left
// unset. A stalled result holds the input register, and in_ready drops
// only while both the input and output registers are full.
module servo_command_frame_decoder import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        applied,
	output logic [15:0] move_duration,
	output logic [15:0] pulse_ch0,
	output logic [15:0] pulse_ch1,
	output logic [15:0] pulse_ch2,
	output logic [15:0] pulse_ch3,
	output logic [15:0] pulse_ch4,
	output logic [15:0] pulse_ch5
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// output register
	logic       out_valid_q;
	result_t    res_q;

	logic        advance;
	logic        fire;
	logic        commit;
	frame_view_t view;
	result_t     res;

	// stage 1 moves on when the output register is empty or being drained
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;
	assign commit = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= frame_end;
		end
	end

	sfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.last    (last_s1),
		.rx_byte (byte_s1),
		.view    (view)
	);

	sfd_goal_store u_goals (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.view   (view),
		.res    (res)
	);

	// result beat only for the last byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign applied = res_q.applied;
	assign move_duration = res_q.move_duration;
	assign pulse_ch0 = res_q.pulse[0];
	assign pulse_ch1 = res_q.pulse[1];
	assign pulse_ch2 = res_q.pulse[2];
	assign pulse_ch3 = res_q.pulse[3];
	assign pulse_ch4 = res_q.pulse[4];
	assign pulse_ch5 = res_q.pulse[5];

endmodule
